// File: rtl/core/sli_pkg.sv
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and constants for the sorted byte list block: item and result
// payloads, status codes, and the command and status groups between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package sli_pkg;

    localparam int LIST_DEPTH_DEF = 16;
    localparam int COUNT_FIELD_W  = 5;

    typedef enum logic [2:0] {
        ST_INSERTED  = 3'd0,
        ST_DELETED   = 3'd1,
        ST_NOT_FOUND = 3'd2,
        ST_FULL      = 3'd3,
        ST_EMPTY     = 3'd4
    } status_t;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_DELETE = 1'b1
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [7:0] value;
    } item_t;

    typedef struct packed {
        status_t                  status;
        logic [COUNT_FIELD_W-1:0] entry_count;
    } result_t;

    // which entry a memory read fetches: the one at the pointer or a neighbour
    typedef enum logic [1:0] {
        RD_PREV = 2'd0,
        RD_CUR  = 2'd1,
        RD_NEXT = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        logic    rd_en;
        rd_sel_t rd_sel;
        logic    wr_en;
        logic    wr_value;
        logic    ptr_inc;
        logic    ptr_dec;
        logic    cnt_inc;
        logic    cnt_dec;
    } dp_cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
        logic ptr_zero;
        logic ptr_end;
        logic ptr_last;
        logic ge;
        logic eq;
    } dp_stat_t;

endpackage

// File: rtl/core/sli_datapath.sv
// ----------------------------------------------------------------------------
// sli_datapath
// Entry memory, entry count, walk pointer and item registers. Carries out
// the read, write, move and count commands of the controller one step at a time.
// ----------------------------------------------------------------------------
module sli_datapath
    import sli_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  item_t                          item,
    input  dp_cmd_t                        cmd,
    output dp_stat_t                       stat,
    output logic [$clog2(LIST_DEPTH+1)-1:0] count
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);
    localparam int IDX_W = $clog2(LIST_DEPTH);

    logic [7:0]       mem [LIST_DEPTH];
    logic [7:0]       rd_data_reg;
    logic [7:0]       value_reg;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [CNT_W-1:0] rd_addr;
    logic [CNT_W:0]   ptr_plus;

    assign ptr_plus = {1'b0, ptr_reg} + (CNT_W+1)'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_PREV: rd_addr = ptr_reg - CNT_W'(1);
            RD_CUR:  rd_addr = ptr_reg;
            RD_NEXT: rd_addr = ptr_plus[CNT_W-1:0];
            default: rd_addr = ptr_reg;
        endcase
    end

    always_comb
    begin
        ptr_next = ptr_reg;
        if (cmd.load)
        begin
            // insert walks down from the top, delete searches up from the bottom
            ptr_next = (item.op == OP_DELETE) ? '0 : count_reg;
        end
        else if (cmd.ptr_inc)
        begin
            ptr_next = ptr_plus[CNT_W-1:0];
        end
        else if (cmd.ptr_dec)
        begin
            ptr_next = ptr_reg - CNT_W'(1);
        end

        count_next = count_reg;
        if (cmd.cnt_inc)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.cnt_dec)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            ptr_reg   <= ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            value_reg <= item.value;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[rd_addr[IDX_W-1:0]];
        end
        if (cmd.wr_en)
        begin
            mem[ptr_reg[IDX_W-1:0]] <= cmd.wr_value ? value_reg : rd_data_reg;
        end
    end

    assign stat.full     = (count_reg >= CNT_W'(LIST_DEPTH));
    assign stat.empty    = (count_reg == '0);
    assign stat.ptr_zero = (ptr_reg == '0);
    assign stat.ptr_end  = (ptr_reg == count_reg);
    assign stat.ptr_last = (ptr_plus >= {1'b0, count_reg});
    assign stat.ge       = (rd_data_reg >= value_reg);
    assign stat.eq       = (rd_data_reg == value_reg);

    assign count = count_reg;

endmodule

// File: rtl/core/sli_controller.sv
// ----------------------------------------------------------------------------
// sli_controller
// Sequencer for insert and delete: walks the list one entry at a time,
// issuing a memory read and then a compare and move for each step.
// ----------------------------------------------------------------------------
module sli_controller
    import sli_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  op_t      op,
    input  dp_stat_t stat,
    output dp_cmd_t  cmd,
    output logic     busy,
    output logic     done,
    output status_t  status
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_INS_TEST = 8'b0000_0010,
        S_INS_WR   = 8'b0000_0100,
        S_DEL_TEST = 8'b0000_1000,
        S_DEL_CHK  = 8'b0001_0000,
        S_SHF_TEST = 8'b0010_0000,
        S_SHF_WR   = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } state_t;

    state_t  state_reg, state_next;
    status_t status_reg, status_next;

    always_comb
    begin
        state_next  = state_reg;
        status_next = status_reg;
        cmd         = '0;
        cmd.rd_sel  = RD_CUR;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd.load = 1'b1;
                    if (op == OP_INSERT)
                    begin
                        if (stat.full)
                        begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end
                        else
                        begin
                            state_next = S_INS_TEST;
                        end
                    end
                    else if (stat.empty)
                    begin
                        status_next = ST_EMPTY;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_DEL_TEST;
                    end
                end
            end
            S_INS_TEST:
            begin
                if (stat.ptr_zero)
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_value = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    status_next  = ST_INSERTED;
                    state_next   = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_PREV;
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR:
            begin
                // entry below is not smaller: move it up one place
                if (stat.ge)
                begin
                    cmd.wr_en   = 1'b1;
                    cmd.ptr_dec = 1'b1;
                    state_next  = S_INS_TEST;
                end
                else
                begin
                    cmd.wr_en    = 1'b1;
                    cmd.wr_value = 1'b1;
                    cmd.cnt_inc  = 1'b1;
                    status_next  = ST_INSERTED;
                    state_next   = S_DONE;
                end
            end
            S_DEL_TEST:
            begin
                if (stat.ptr_end)
                begin
                    status_next = ST_NOT_FOUND;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_CUR;
                    state_next = S_DEL_CHK;
                end
            end
            S_DEL_CHK:
            begin
                if (stat.eq)
                begin
                    state_next = S_SHF_TEST;
                end
                else
                begin
                    cmd.ptr_inc = 1'b1;
                    state_next  = S_DEL_TEST;
                end
            end
            S_SHF_TEST:
            begin
                if (stat.ptr_last)
                begin
                    cmd.cnt_dec = 1'b1;
                    status_next = ST_DELETED;
                    state_next  = S_DONE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = RD_NEXT;
                    state_next = S_SHF_WR;
                end
            end
            S_SHF_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.ptr_inc = 1'b1;
                state_next  = S_SHF_TEST;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            status_reg <= ST_INSERTED;
        end
        else
        begin
            state_reg  <= state_next;
            status_reg <= status_next;
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = (state_reg == S_DONE);
    assign status = status_reg;

endmodule

// File: rtl/core/sorted_list_insert_delete.sv
// ----------------------------------------------------------------------------
// sorted_list_insert_delete
// Ascending list of byte values with ordered insert and first-match delete.
// ----------------------------------------------------------------------------
// Usage:
//   An item (op, value) is taken at a rising edge with start high and busy
//   low. Busy stays high until the result has been shown. The result
//   (status, entry_count) is on the result port for one cycle with done high;
//   the receiver cannot stall and must take it then.
//   Insert places the value ahead of the first entry not smaller than it;
//   delete removes the lowest-placed equal entry. A full list refuses an
//   insert, an empty list reports empty on delete.
//   Sequence from accept to done: a refused item goes straight to done;
//   otherwise each entry walked over takes a memory read, then a compare
//   and move.
//   The walk runs over a single-port entry memory; one item
//   is in the block at a time and the next may be taken the cycle after done.
//   Reset empties the list at once: the count clears and no clearing pass
//   runs, since entries above the count are never read.
// ----------------------------------------------------------------------------
module sorted_list_insert_delete
    import sli_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  item_t   item,
    output logic    done,
    output result_t result
);

    localparam int CNT_W = $clog2(LIST_DEPTH + 1);

    dp_cmd_t          cmd;
    dp_stat_t         stat;
    status_t          status;
    logic [CNT_W-1:0] count;

    sli_controller u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .op     (item.op),
        .stat   (stat),
        .cmd    (cmd),
        .busy   (busy),
        .done   (done),
        .status (status)
    );

    sli_datapath #(
        .LIST_DEPTH (LIST_DEPTH)
    ) u_dp (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item),
        .cmd   (cmd),
        .stat  (stat),
        .count (count)
    );

    // count field is five bits wide whatever the depth
    assign result.status      = status;
    assign result.entry_count = COUNT_FIELD_W'(count);

endmodule

// File: rtl/core/sli_checker.sv
// ----------------------------------------------------------------------------
// sli_checker
// Port-level checks on the command handshake, result strobe and result
// fields of the sorted byte list, bound to the top level.
// ----------------------------------------------------------------------------
module sli_checker
    import sli_pkg::*;
#(
    parameter int LIST_DEPTH = LIST_DEPTH_DEF
)
(
    input logic    clk,
    input logic    rst_n,
    input logic    start,
    input logic    busy,
    input logic    done,
    input result_t result
);

    // an accepted item holds the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("busy not raised after accept");

    // result strobe lasts one cycle and frees the block
    a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done && !busy)
        else $error("done longer than one cycle or block still busy");

    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy)
        else $error("done shown while idle");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.status == ST_INSERTED || result.status == ST_DELETED ||
                  result.status == ST_NOT_FOUND || result.status == ST_FULL ||
                  result.status == ST_EMPTY))
        else $error("undefined status code");

    // a refused insert leaves the count where it was, so its field cannot be zero unless the depth exceeds 31
    a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
        done && result.status == ST_FULL |-> result.entry_count != '0 ||
                                             LIST_DEPTH > 31)
        else $error("full reported on an empty list");

endmodule

bind sorted_list_insert_delete sli_checker #(
    .LIST_DEPTH (LIST_DEPTH)
) u_sli_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// File: tb/tb_sorted_list_insert_delete.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sorted_list_insert_delete
// Self-checking bench for the sorted byte list. A shadow copy of the list
// predicts status and entry count for every accepted item. A monitor compares
// each strobed result with the oldest prediction. Directed cases cover empty,
// full, not found, zero and top byte values. Random items then swing the fill
// level between empty and full under three sender idle rates.
// ----------------------------------------------------------------------------
module tb_sorted_list_insert_delete;
    import sli_pkg::*;

    localparam int DEPTH       = LIST_DEPTH_DEF;
    localparam int STALL_LIMIT = 2000;
    localparam int DRAIN_WAIT  = 2 * DEPTH + 8;

    logic    clk;
    logic    rst_n;
    logic    start;
    logic    busy;
    item_t   item;
    logic    done;
    result_t result;

    logic [7:0] shadow_list[$];
    result_t    pending_results[$];
    int         sender_idle_pct;
    int         fail_count;
    int         items_sent;
    int         results_checked;
    int         status_seen[5];
    int         quiet_cycles;

    sorted_list_insert_delete #(
        .LIST_DEPTH(DEPTH)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .item(item),
        .done(done),
        .result(result)
    );

    always #6 clk = ~clk;

    // updates the shadow list and gives the expected result of one item
    function automatic result_t predict_list_op(input item_t it);
        result_t    res;
        int         pos;
        logic [7:0] v;
        v   = it.value;
        pos = 0;
        if (it.op == OP_INSERT)
        begin
            if (shadow_list.size() >= DEPTH)
            begin
                res.status = ST_FULL;
            end
            else
            begin
                while (pos < shadow_list.size() && v > shadow_list[pos])
                    pos++;
                shadow_list.insert(pos, v);
                res.status = ST_INSERTED;
            end
        end
        else
        begin
            if (shadow_list.size() == 0)
            begin
                res.status = ST_EMPTY;
            end
            else
            begin
                while (pos < shadow_list.size() && shadow_list[pos] != v)
                    pos++;
                if (pos >= shadow_list.size())
                begin
                    res.status = ST_NOT_FOUND;
                end
                else
                begin
                    shadow_list.delete(pos);
                    res.status = ST_DELETED;
                end
            end
        end
        res.entry_count = COUNT_FIELD_W'(shadow_list.size());
        return res;
    endfunction

    // start stays high from one item to the next unless a gap is drawn
    task automatic issue_item(input op_t op, input logic [7:0] value);
        item_t next;
        next.op    = op;
        next.value = value;
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < sender_idle_pct);
        end
        item  <= next;
        start <= 1'b1;
        do
            @(posedge clk);
        while (busy);
        pending_results.push_back(predict_list_op(next));
        items_sent++;
    endtask

    function automatic logic [7:0] pick_value();
        logic [7:0] edge_vals[6];
        edge_vals = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};
        case ($urandom_range(3))
            2: return edge_vals[$urandom_range(5)];
            3: return 8'($urandom_range(7));
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic test_delete_empty();
        issue_item(OP_DELETE, 8'd0);
        issue_item(OP_DELETE, 8'd255);
    endtask

    // zero and top byte, duplicates go in front of equal entries
    task automatic test_extremes();
        issue_item(OP_INSERT, 8'd255);
        issue_item(OP_INSERT, 8'd0);
        issue_item(OP_INSERT, 8'd0);
        issue_item(OP_DELETE, 8'd0);
        issue_item(OP_DELETE, 8'd0);
        issue_item(OP_DELETE, 8'd255);
    endtask

    task automatic test_not_found();
        issue_item(OP_INSERT, 8'd128);
        issue_item(OP_DELETE, 8'd127);
        issue_item(OP_DELETE, 8'd129);
    endtask

    task automatic test_full();
        int i;
        for (i = 1; i < DEPTH; i++)
            issue_item(OP_INSERT, (i % 3 == 0) ? 8'd255 : 8'(i * 37));
        issue_item(OP_INSERT, 8'd0);
        issue_item(OP_INSERT, 8'd255);
    endtask

    task automatic test_random(input int idle_pct, input int n_items);
        int i;
        int insert_pct;
        int bias_sel;
        sender_idle_pct = idle_pct;
        insert_pct      = 50;
        for (i = 0; i < n_items; i++)
        begin
            // fill level drifts towards full or empty, or stays balanced, in runs
            if (i % 40 == 0)
            begin
                bias_sel   = $urandom_range(2);
                insert_pct = (bias_sel == 0) ? 15 : (bias_sel == 1) ? 50 : 85;
            end
            if ($urandom_range(99) < insert_pct)
                issue_item(OP_INSERT, pick_value());
            else if (shadow_list.size() > 0 && $urandom_range(99) < 75)
                issue_item(OP_DELETE, shadow_list[$urandom_range(shadow_list.size() - 1)]);
            else
                issue_item(OP_DELETE, pick_value());
        end
    endtask

    always @(posedge clk)
    begin
        result_t exp_res;
        if (rst_n && done)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no item outstanding: status %0d, entry_count %0d",
                       result.status, result.entry_count);
                fail_count++;
            end
            else
            begin
                exp_res = pending_results.pop_front();
                results_checked++;
                if (exp_res.status <= ST_EMPTY)
                    status_seen[exp_res.status]++;
                if (result.status !== exp_res.status)
                begin
                    $error("status: expected %0d, actual %0d",
                           exp_res.status, result.status);
                    fail_count++;
                end
                if (result.entry_count !== exp_res.entry_count)
                begin
                    $error("entry_count: expected %0d, actual %0d",
                           exp_res.entry_count, result.entry_count);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        clk             = 1'b0;
        rst_n           = 1'b0;
        start           = 1'b0;
        item            = '0;
        sender_idle_pct = 0;
        fail_count      = 0;
        items_sent      = 0;
        results_checked = 0;
        quiet_cycles    = 0;
        status_seen     = '{default: 0};
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_delete_empty();
        test_extremes();
        test_not_found();
        test_full();
        test_random(23, 333);
        test_random(64, 333);
        test_random(0, 334);

        start <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("%0d items sent, %0d results checked", items_sent, results_checked);
        $display("inserted %0d, deleted %0d, not found %0d, full %0d, empty %0d",
                 status_seen[ST_INSERTED], status_seen[ST_DELETED],
                 status_seen[ST_NOT_FOUND], status_seen[ST_FULL], status_seen[ST_EMPTY]);
        if (fail_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
